### rtl/bavg_pkg.sv
package bavg_pkg;

   // Sizing
   localparam int MaxOutColumns = 512;
   localparam int PixelBits     = 8;
   localparam int ColAddrWidth  = (MaxOutColumns > 1) ? $clog2(MaxOutColumns) : 1;

   // Fixed field and state widths
   localparam int CfgDataWidth = 13;
   localparam int SizeWidth    = 13;
   localparam int BlockWidth   = 7;
   localparam int PosWidth     = 12;
   localparam int CountWidth   = 6;
   localparam int SumWidth     = 14;
   localparam int IterWidth    = $clog2(SumWidth + 1);

   localparam logic [SizeWidth-1:0]  ImageSizeMax     = 13'd4096;
   localparam logic [BlockWidth-1:0] BlockSizeMax     = 7'd64;
   localparam logic [SizeWidth-1:0]  ImageWidthReset  = 13'd640;
   localparam logic [SizeWidth-1:0]  ImageHeightReset = 13'd480;
   localparam logic [BlockWidth-1:0] BlockWidthReset  = 7'd8;
   localparam logic [BlockWidth-1:0] BlockHeightReset = 7'd8;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_BLOCK_WIDTH  = 2'd2,
      CSR_BLOCK_HEIGHT = 2'd3
   } csr_index_type;

   // Operand pair fed to the shared divider
   typedef enum logic [2:0] {
      DIV_SRC_WIDTH  = 3'd0,
      DIV_SRC_HEIGHT = 3'd1,
      DIV_SRC_HSUM   = 3'd2,
      DIV_SRC_COLUMN = 3'd3,
      DIV_SRC_VSUM   = 3'd4
   } div_src_type;

   typedef struct packed {
      logic        clear;
      logic        take;
      logic        accum;
      logic        div_start;
      div_src_type div_src;
      logic        cfg_start;
      logic        cap_ba;
      logic        cap_bd;
      logic        cap_lim;
      logic        cap_avg;
      logic        cap_x;
      logic        mem_rd;
      logic        mem_wr;
      logic        load_out;
      logic        step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic cfg_dirty;
      logic blk_done;
      logic div_done;
      logic x_kept;
      logic block_row_end;
      logic out_free;
   } sts_type;

   function automatic logic [SizeWidth-1:0] clamp_size(input logic [SizeWidth-1:0] v);
      logic [SizeWidth-1:0] r;
      if (v == '0) begin
         r = SizeWidth'(1);
      end else if (v > ImageSizeMax) begin
         r = ImageSizeMax;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [BlockWidth-1:0] clamp_block(input logic [BlockWidth-1:0] v);
      logic [BlockWidth-1:0] r;
      if (v == '0) begin
         r = BlockWidth'(1);
      end else if (v > BlockSizeMax) begin
         r = BlockSizeMax;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### rtl/bavg_div.sv
module bavg_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [bavg_pkg::SumWidth-1:0]       dividend,
   input  logic [bavg_pkg::BlockWidth-1:0]     divisor,
   output logic                                done,
   output logic [bavg_pkg::SumWidth-1:0]       quotient
);

   // restoring divider, one quotient bit per cycle, MSB first
   logic [bavg_pkg::BlockWidth-1:0] rem_ff, rem_in;
   logic [bavg_pkg::SumWidth-1:0]   quo_ff, quo_in;
   logic [bavg_pkg::BlockWidth-1:0] dvs_ff, dvs_in;
   logic [bavg_pkg::IterWidth-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [bavg_pkg::BlockWidth:0]   shifted;
   logic [bavg_pkg::BlockWidth:0]   diff;
   logic                            ge;

   assign shifted = {rem_ff, quo_ff[bavg_pkg::SumWidth-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = bavg_pkg::IterWidth'(bavg_pkg::SumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[bavg_pkg::BlockWidth-1:0] : shifted[bavg_pkg::BlockWidth-1:0];
         quo_in = {quo_ff[bavg_pkg::SumWidth-2:0], ge};
         cnt_in = cnt_ff - bavg_pkg::IterWidth'(1);
         if (cnt_ff == bavg_pkg::IterWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/bavg_ctrl.sv
module bavg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bavg_pkg::sts_type sts,
   output bavg_pkg::cmd_type cmd
);

   typedef enum logic [12:0] {
      S_CLEAR   = 13'b0000000000001,
      S_IDLE    = 13'b0000000000010,
      S_CFG_BA  = 13'b0000000000100,
      S_CFG_BD  = 13'b0000000001000,
      S_CFG_LIM = 13'b0000000010000,
      S_EVAL    = 13'b0000000100000,
      S_DIV_AVG = 13'b0000001000000,
      S_DIV_X   = 13'b0000010000000,
      S_MEM_RD  = 13'b0000100000000,
      S_MEM_WR  = 13'b0001000000000,
      S_DIV_V   = 13'b0010000000000,
      S_OUT     = 13'b0100000000000,
      S_STEP    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (sts.cfg_dirty) begin
               cmd.cfg_start = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_src   = bavg_pkg::DIV_SRC_WIDTH;
               state_in      = S_CFG_BA;
            end else begin
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.take = 1'b1;
                  state_in = S_EVAL;
               end
            end
         end
         S_CFG_BA: begin
            if (sts.div_done) begin
               cmd.cap_ba    = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_src   = bavg_pkg::DIV_SRC_HEIGHT;
               state_in      = S_CFG_BD;
            end
         end
         S_CFG_BD: begin
            if (sts.div_done) begin
               cmd.cap_bd = 1'b1;
               state_in   = S_CFG_LIM;
            end
         end
         S_CFG_LIM: begin
            cmd.cap_lim = 1'b1;
            state_in    = S_IDLE;
         end
         S_EVAL: begin
            cmd.accum = 1'b1;
            if (sts.blk_done) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = bavg_pkg::DIV_SRC_HSUM;
               state_in      = S_DIV_AVG;
            end else begin
               state_in = S_STEP;
            end
         end
         S_DIV_AVG: begin
            if (sts.div_done) begin
               cmd.cap_avg   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_src   = bavg_pkg::DIV_SRC_COLUMN;
               state_in      = S_DIV_X;
            end
         end
         S_DIV_X: begin
            if (sts.div_done) begin
               cmd.cap_x = 1'b1;
               state_in  = S_MEM_RD;
            end
         end
         S_MEM_RD: begin
            if (sts.x_kept) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_MEM_WR;
            end else begin
               state_in = S_STEP;
            end
         end
         S_MEM_WR: begin
            cmd.mem_wr = 1'b1;
            if (sts.block_row_end) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = bavg_pkg::DIV_SRC_VSUM;
               state_in      = S_DIV_V;
            end else begin
               state_in = S_STEP;
            end
         end
         S_DIV_V: begin
            if (sts.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_STEP;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/bavg_dp.sv
module bavg_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [1:0]                            csr_index,
   input  logic [bavg_pkg::CfgDataWidth-1:0]     csr_write_data,
   input  logic [7:0]                            req_pixel,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [7:0]                            rsp_average,
   output logic [8:0]                            rsp_out_column,
   output logic [11:0]                           rsp_out_row,
   output logic                                  rsp_frame_end,
   input  bavg_pkg::cmd_type                     cmd,
   output bavg_pkg::sts_type                     sts
);

   localparam int SW = bavg_pkg::SizeWidth;
   localparam int BW = bavg_pkg::BlockWidth;
   localparam int PW = bavg_pkg::PosWidth;
   localparam int CW = bavg_pkg::CountWidth;
   localparam int UW = bavg_pkg::SumWidth;
   localparam int AW = bavg_pkg::ColAddrWidth;

   // config registers and derived frame geometry
   logic [SW-1:0] image_width_ff, image_width_in;
   logic [SW-1:0] image_height_ff, image_height_in;
   logic [BW-1:0] block_width_ff, block_width_in;
   logic [BW-1:0] block_height_ff, block_height_in;
   logic          cfg_dirty_ff, cfg_dirty_in;
   logic [SW-1:0] ba_ff, ba_in;
   logic [SW-1:0] bd_ff, bd_in;
   logic [SW-1:0] col_limit_ff, col_limit_in;
   logic [SW-1:0] row_limit_ff, row_limit_in;

   // scan state
   logic [bavg_pkg::PixelBits-1:0] pix_ff, pix_in;
   logic [UW-1:0] hsum_ff, hsum_in;
   logic [CW-1:0] pib_ff, pib_in;
   logic [PW-1:0] colpos_ff, colpos_in;
   logic [PW-1:0] rowpos_ff, rowpos_in;
   logic [CW-1:0] rib_ff, rib_in;
   logic [PW-1:0] ori_ff, ori_in;
   logic          blk_ff, blk_in;
   logic [UW-1:0] avg_ff, avg_in;
   logic [PW-1:0] x_ff, x_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_average_ff, rsp_average_in;
   logic [8:0]    rsp_column_ff, rsp_column_in;
   logic [11:0]   rsp_row_ff, rsp_row_in;
   logic          rsp_end_ff, rsp_end_in;

   // column sum store
   logic [UW-1:0] vsum_mem [bavg_pkg::MaxOutColumns];
   logic [UW-1:0] rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [UW-1:0] mem_wdata;
   logic [AW-1:0] x_addr;

   logic [SW-1:0] w, h;
   logic [BW-1:0] bw, bh;
   logic          row_used, col_used;
   logic [UW-1:0] hsum_sum;
   logic [CW:0]   pib_inc;
   logic          blk_done;
   logic [UW-1:0] vnew;
   logic [SW-1:0] kept_cols;
   logic          last;
   logic [SW+BW-1:0] col_prod, row_prod;
   logic [SW:0]   col_next, row_next;
   logic [CW:0]   rib_next;

   logic [UW-1:0] div_dividend;
   logic [BW-1:0] div_divisor;
   logic          div_done;
   logic [UW-1:0] div_quotient;

   assign w  = bavg_pkg::clamp_size(image_width_ff);
   assign h  = bavg_pkg::clamp_size(image_height_ff);
   assign bw = bavg_pkg::clamp_block(block_width_ff);
   assign bh = bavg_pkg::clamp_block(block_height_ff);

   assign row_used = {1'b0, rowpos_ff} < row_limit_ff;
   assign col_used = {1'b0, colpos_ff} < col_limit_ff;
   assign hsum_sum = hsum_ff + UW'(pix_ff);
   assign pib_inc  = {1'b0, pib_ff} + (CW+1)'(1);
   assign blk_done = row_used && col_used && (pib_inc >= bw);
   assign vnew     = (rib_ff == '0) ? avg_ff : rdata_ff + avg_ff;

   assign col_prod = {{BW{1'b0}}, ba_ff} * {{SW{1'b0}}, bw};
   assign row_prod = {{BW{1'b0}}, bd_ff} * {{SW{1'b0}}, bh};

   assign kept_cols = (ba_ff < SW'(bavg_pkg::MaxOutColumns)) ? ba_ff
                                                             : SW'(bavg_pkg::MaxOutColumns);
   assign last = (({1'b0, x_ff} + SW'(1)) == kept_cols) &&
                 (({1'b0, ori_ff} + SW'(1)) == bd_ff);

   assign x_addr = x_ff[AW-1:0];

   // shared divider operand select
   always_comb begin
      div_dividend = {1'b0, w};
      div_divisor  = bw;
      case (cmd.div_src)
         bavg_pkg::DIV_SRC_WIDTH: begin
            div_dividend = {1'b0, w};
            div_divisor  = bw;
         end
         bavg_pkg::DIV_SRC_HEIGHT: begin
            div_dividend = {1'b0, h};
            div_divisor  = bh;
         end
         bavg_pkg::DIV_SRC_HSUM: begin
            div_dividend = hsum_sum;
            div_divisor  = bw;
         end
         bavg_pkg::DIV_SRC_COLUMN: begin
            div_dividend = UW'(colpos_ff);
            div_divisor  = bw;
         end
         bavg_pkg::DIV_SRC_VSUM: begin
            div_dividend = vnew;
            div_divisor  = bh;
         end
         default: begin
            div_dividend = {1'b0, w};
            div_divisor  = bw;
         end
      endcase
   end

   bavg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // config writes
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      block_width_in  = block_width_ff;
      block_height_in = block_height_ff;
      cfg_dirty_in    = cfg_dirty_ff & ~cmd.cfg_start;
      if (csr_write_enable) begin
         cfg_dirty_in = 1'b1;
         unique case (csr_index)
            bavg_pkg::CSR_IMAGE_WIDTH:  image_width_in  = csr_write_data;
            bavg_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_write_data;
            bavg_pkg::CSR_BLOCK_WIDTH:  block_width_in  = csr_write_data[BW-1:0];
            bavg_pkg::CSR_BLOCK_HEIGHT: block_height_in = csr_write_data[BW-1:0];
            default: ;
         endcase
      end
   end

   // geometry and operand captures
   always_comb begin
      ba_in        = cmd.cap_ba  ? div_quotient[SW-1:0] : ba_ff;
      bd_in        = cmd.cap_bd  ? div_quotient[SW-1:0] : bd_ff;
      col_limit_in = cmd.cap_lim ? col_prod[SW-1:0]     : col_limit_ff;
      row_limit_in = cmd.cap_lim ? row_prod[SW-1:0]     : row_limit_ff;
      avg_in       = cmd.cap_avg ? div_quotient         : avg_ff;
      x_in         = cmd.cap_x   ? div_quotient[PW-1:0] : x_ff;
      pix_in       = cmd.take    ? req_pixel[bavg_pkg::PixelBits-1:0] : pix_ff;
      clr_cnt_in   = cmd.clear   ? clr_cnt_ff + AW'(1)  : clr_cnt_ff;
   end

   // scan counters
   always_comb begin
      hsum_in   = hsum_ff;
      pib_in    = pib_ff;
      colpos_in = colpos_ff;
      rowpos_in = rowpos_ff;
      rib_in    = rib_ff;
      ori_in    = ori_ff;
      blk_in    = blk_ff;
      col_next  = {1'b0, colpos_ff} + (SW+1)'(1);
      row_next  = {1'b0, rowpos_ff} + (SW+1)'(1);
      rib_next  = {1'b0, rib_ff} + (CW+1)'(1);
      if (cmd.accum) begin
         blk_in = blk_done;
         if (row_used && col_used) begin
            hsum_in = hsum_sum;
            pib_in  = pib_inc[CW-1:0];
         end
      end
      if (cmd.step) begin
         blk_in = 1'b0;
         if (blk_ff) begin
            hsum_in = '0;
            pib_in  = '0;
         end
         if (col_next >= {1'b0, w}) begin
            colpos_in = '0;
            hsum_in   = '0;
            pib_in    = '0;
            if (row_used) begin
               if (rib_next >= bh) begin
                  rib_in = '0;
                  ori_in = ori_ff + PW'(1);
               end else begin
                  rib_in = rib_next[CW-1:0];
               end
            end
            if (row_next >= {1'b0, h}) begin
               rowpos_in = '0;
               rib_in    = '0;
               ori_in    = '0;
            end else begin
               rowpos_in = row_next[PW-1:0];
            end
         end else begin
            colpos_in = col_next[PW-1:0];
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      rsp_column_in  = rsp_column_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_end_in     = rsp_end_ff;
      if (cmd.load_out) begin
         rsp_valid_in   = 1'b1;
         rsp_average_in = div_quotient[7:0];
         rsp_column_in  = x_ff[8:0];
         rsp_row_in     = ori_ff;
         rsp_end_in     = last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // store port: clearing sweep or column update
   assign mem_we    = cmd.clear | cmd.mem_wr;
   assign mem_waddr = cmd.clear ? clr_cnt_ff : x_addr;
   assign mem_wdata = cmd.clear ? '0 : vnew;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vsum_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= vsum_mem[x_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= bavg_pkg::ImageWidthReset;
         image_height_ff <= bavg_pkg::ImageHeightReset;
         block_width_ff  <= bavg_pkg::BlockWidthReset;
         block_height_ff <= bavg_pkg::BlockHeightReset;
         cfg_dirty_ff    <= 1'b1;
         hsum_ff         <= '0;
         pib_ff          <= '0;
         colpos_ff       <= '0;
         rowpos_ff       <= '0;
         rib_ff          <= '0;
         ori_ff          <= '0;
         blk_ff          <= 1'b0;
         clr_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         block_width_ff  <= block_width_in;
         block_height_ff <= block_height_in;
         cfg_dirty_ff    <= cfg_dirty_in;
         hsum_ff         <= hsum_in;
         pib_ff          <= pib_in;
         colpos_ff       <= colpos_in;
         rowpos_ff       <= rowpos_in;
         rib_ff          <= rib_in;
         ori_ff          <= ori_in;
         blk_ff          <= blk_in;
         clr_cnt_ff      <= clr_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ba_ff          <= ba_in;
      bd_ff          <= bd_in;
      col_limit_ff   <= col_limit_in;
      row_limit_ff   <= row_limit_in;
      avg_ff         <= avg_in;
      x_ff           <= x_in;
      pix_ff         <= pix_in;
      rsp_average_ff <= rsp_average_in;
      rsp_column_ff  <= rsp_column_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_end_ff     <= rsp_end_in;
   end

   always_comb begin
      sts.clear_last    = clr_cnt_ff == AW'(bavg_pkg::MaxOutColumns - 1);
      sts.cfg_dirty     = cfg_dirty_ff;
      sts.blk_done      = blk_done;
      sts.div_done      = div_done;
      sts.x_kept        = {1'b0, x_ff} < SW'(bavg_pkg::MaxOutColumns);
      sts.block_row_end = ({1'b0, rib_ff} + (CW+1)'(1)) >= bh;
      sts.out_free      = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = rsp_average_ff;
   assign rsp_out_column = rsp_column_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_frame_end  = rsp_end_ff;

endmodule

### rtl/block_average_downsampler_top.sv
// channel   ports                                      direction
// --------  -----------------------------------------  ---------------------------
// req       req_valid, req_stall, req_pixel            pixel words in, raster order
// rsp       rsp_valid, rsp_stall, rsp_average,         averaged words out
//           rsp_out_column, rsp_out_row, rsp_frame_end
// csr       csr_write_enable, csr_index, csr_write_data register writes, no read-back
//
// One word at a time. A pixel that does not close a block is evaluated and stepped;
// closing a block adds two passes of the shared 14-iteration divider (column average
// and output column) and a column store update, skipped past the store's last column,
// plus a third pass (vertical average) and any rsp_stall wait when it also closes a
// block row. Reset clears all 512 column sum store entries, then runs a geometry pass,
// which any csr write reruns. A stalled result still lets the next word in.
module block_average_downsampler_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_average,
   output logic [8:0]  rsp_out_column,
   output logic [11:0] rsp_out_row,
   output logic        rsp_frame_end,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_write_data
);

   bavg_pkg::cmd_type cmd;
   bavg_pkg::sts_type sts;

   // sequencer: clear sweep, geometry pass, per-word steps
   bavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // counters, column sum store, divider, result register
   bavg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_pixel        (req_pixel),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_average      (rsp_average),
      .rsp_out_column   (rsp_out_column),
      .rsp_out_row      (rsp_out_row),
      .rsp_frame_end    (rsp_frame_end),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

### rtl/bavg_checker.sv
module bavg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_average,
   input logic [8:0]  rsp_out_column,
   input logic [11:0] rsp_out_row,
   input logic        rsp_frame_end
);

   // no word taken during or right after reset (clearing pass)
   a_reset_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("req taken right after reset");

   // one word in flight: the cycle after a take is always stalled
   a_take_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req words taken back to back");

   // a new result never shows up while a pixel word is being taken
   a_rise_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall)
      else $error("result appeared while req open");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_average) && $stable(rsp_out_column) &&
                                 $stable(rsp_out_row) && $stable(rsp_frame_end))
      else $error("rsp word changed while stalled");

endmodule

bind block_average_downsampler_top bavg_checker u_bavg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_average    (rsp_average),
   .rsp_out_column (rsp_out_column),
   .rsp_out_row    (rsp_out_row),
   .rsp_frame_end  (rsp_frame_end)
);

### tb/block_average_downsampler_top_tb.sv
module block_average_downsampler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Quiet cycles allowed before the run is declared hung. Covers the reset
   // clearing pass, a block-row close and long random gaps or stalls at
   // 84 percent.
   localparam int WatchdogLimit = 4000;
   // Cycles to let pass once nothing is expected any more: a pixel that
   // closes a block without a result can still be in the divider.
   localparam int DrainCycles = 64;

   // One expected output pixel of the reduced image
   typedef struct {
      logic [7:0]  average;
      logic [8:0]  out_column;
      logic [11:0] out_row;
      logic        frame_end;
   } block_result_type;

   logic          clock;
   logic          reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_pixel = '0;

   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [7:0]    rsp_average;
   logic [8:0]    rsp_out_column;
   logic [11:0]   rsp_out_row;
   logic          rsp_frame_end;

   logic          csr_write_enable = 1'b0;
   bavg_pkg::csr_index_type csr_index = bavg_pkg::CSR_IMAGE_WIDTH;
   logic [12:0]   csr_write_data = '0;

   block_average_downsampler_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_average      (rsp_average),
      .rsp_out_column   (rsp_out_column),
      .rsp_out_row      (rsp_out_row),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the register file, raw as written (block sizes keep
   // only their low 7 bits). Clamping happens per pixel, as in the block.
   // ------------------------------------------------------------------
   logic [12:0] cfg_image_width  = bavg_pkg::ImageWidthReset;
   logic [12:0] cfg_image_height = bavg_pkg::ImageHeightReset;
   logic [6:0]  cfg_block_width  = bavg_pkg::BlockWidthReset;
   logic [6:0]  cfg_block_height = bavg_pkg::BlockHeightReset;

   // Decimator state. Pixel, position and block-row counts are one bit wider
   // than the block's so a count reaching the limit (64, 4096) compares right.
   logic [13:0] row_sum        = '0;   // running sum of the current block in a row
   logic [6:0]  row_sum_pixels = '0;
   logic [12:0] col_pos        = '0;
   logic [12:0] row_pos        = '0;
   logic [6:0]  block_rows     = '0;   // rows already folded into column_sums
   logic [11:0] out_row_idx    = '0;
   logic [13:0] column_sums [bavg_pkg::MaxOutColumns] = '{default: '0};

   block_result_type expected_blocks [$];  // output pixels still owed by the block
   logic [7:0]       pending_pixels  [$];  // pixel words not yet accepted

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   logic pixel_taken  = 1'b0;

   // 0 counts as 1, anything above the ceiling counts as the ceiling
   function automatic int unsigned dim_limit(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // Folds one accepted pixel into the box filter and queues the output
   // pixel it completes, if any.
   function automatic void accumulate_pixel(input logic [7:0] pix);
      int unsigned      w, h, bw, bh, across, down, kept, avg, x;
      logic             row_used, col_used;
      block_result_type res;
      w      = dim_limit(cfg_image_width, bavg_pkg::ImageSizeMax);
      h      = dim_limit(cfg_image_height, bavg_pkg::ImageSizeMax);
      bw     = dim_limit(cfg_block_width, bavg_pkg::BlockSizeMax);
      bh     = dim_limit(cfg_block_height, bavg_pkg::BlockSizeMax);
      across = w / bw;
      down   = h / bh;
      kept   = (across < bavg_pkg::MaxOutColumns) ? across : bavg_pkg::MaxOutColumns;
      // edge pixels right of the last full block / below the last block row
      row_used = (row_pos < down * bh);
      col_used = (col_pos < across * bw);

      if (row_used && col_used) begin
         row_sum        = row_sum + pix;
         row_sum_pixels = row_sum_pixels + 1;
         if (row_sum_pixels >= bw) begin
            avg            = row_sum / bw;
            x              = col_pos / bw;
            row_sum        = '0;
            row_sum_pixels = '0;
            // columns past the store are dropped silently
            if (x < bavg_pkg::MaxOutColumns) begin
               if (block_rows == 0) begin
                  column_sums[x] = 14'(avg);
               end else begin
                  column_sums[x] = column_sums[x] + 14'(avg);
               end
               if (block_rows + 1 >= bh) begin
                  res.average    = 8'(column_sums[x] / bh);
                  res.out_column = 9'(x);
                  res.out_row    = out_row_idx;
                  res.frame_end  = (x + 1 == kept) && (out_row_idx + 1 == down);
                  expected_blocks.push_back(res);
               end
            end
         end
      end

      // row and frame boundaries; >= so a shrunk limit wraps at once
      col_pos = col_pos + 1;
      if (col_pos >= w) begin
         col_pos        = '0;
         row_sum        = '0;
         row_sum_pixels = '0;
         if (row_used) begin
            block_rows = block_rows + 1;
            if (block_rows >= bh) begin
               block_rows  = '0;
               out_row_idx = out_row_idx + 1;
            end
         end
         row_pos = row_pos + 1;
         if (row_pos >= h) begin
            row_pos     = '0;
            block_rows  = '0;
            out_row_idx = '0;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver: changes inputs on the falling edge. A word stays on the bus
   // until taken; a new one goes up right after, unless the sender idles.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || pixel_taken) begin
         if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_pixel <= pending_pixels[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // ------------------------------------------------------------------
   // Monitor: samples on the rising edge. Checks each result word against
   // the oldest expectation, predicts on each accepted pixel word, and
   // runs the watchdog.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      block_result_type want;
      logic             rsp_fire, req_fire;
      rsp_fire = rsp_valid && !rsp_stall;
      req_fire = req_valid && !req_stall;
      if (reset) begin
         pixel_taken  <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         pixel_taken <= req_fire;

         if (rsp_fire) begin
            if (expected_blocks.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("unexpected result word: avg %0d col %0d row %0d end %0b",
                           rsp_average, rsp_out_column, rsp_out_row, rsp_frame_end);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_average !== want.average || rsp_out_column !== want.out_column ||
                   rsp_out_row !== want.out_row || rsp_frame_end !== want.frame_end) begin
                  if (mismatch_count < 10) begin
                     $display("mismatch: expected avg %0d col %0d row %0d end %0b",
                              want.average, want.out_column, want.out_row,
                              want.frame_end);
                     $display("          got      avg %0d col %0d row %0d end %0b",
                              rsp_average, rsp_out_column, rsp_out_row, rsp_frame_end);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end

         if (req_fire) begin
            void'(pending_pixels.pop_front());
            accumulate_pixel(req_pixel);
         end

         if (rsp_fire || req_fire || csr_write_enable) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // One register write; the shadow copy follows the block's masking.
   task automatic write_csr(input bavg_pkg::csr_index_type idx, input logic [12:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         bavg_pkg::CSR_IMAGE_WIDTH:  cfg_image_width  = data;
         bavg_pkg::CSR_IMAGE_HEIGHT: cfg_image_height = data;
         bavg_pkg::CSR_BLOCK_WIDTH:  cfg_block_width  = data[6:0];
         bavg_pkg::CSR_BLOCK_HEIGHT: cfg_block_height = data[6:0];
         default: ;
      endcase
   endtask

   // Sender holds off until every word is taken and every result is in.
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || expected_blocks.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // Mostly small images; now and then 0 or a value of 4096 or more
   function automatic logic [12:0] pick_image_size(input int unsigned typical_max);
      case ($urandom_range(15))
         0:       return 13'd0;
         1:       return 13'($urandom_range(4096, 8191));
         default: return 13'($urandom_range(1, typical_max));
      endcase
   endfunction

   // Block size in the low 7 bits, junk above (the block ignores it)
   function automatic logic [12:0] pick_block_size();
      logic [6:0] b;
      case ($urandom_range(15))
         0:       b = 7'd0;
         1:       b = 7'($urandom_range(64, 127));
         2:       b = 7'($urandom_range(5, 12));
         default: b = 7'($urandom_range(1, 4));
      endcase
      return {6'($urandom), b};
   endfunction

   // Random geometry, then whole frames (sometimes a partial run, which
   // leaves the next geometry change landing mid-frame).
   task automatic run_sessions(input int budget);
      int          sent;
      int unsigned frame, count;
      sent = 0;
      while (sent < budget) begin
         wait_drained();
         if ($urandom_range(4) != 0) begin
            write_csr(bavg_pkg::CSR_IMAGE_WIDTH, pick_image_size(10));
         end
         if ($urandom_range(4) != 0) begin
            write_csr(bavg_pkg::CSR_IMAGE_HEIGHT, pick_image_size(6));
         end
         if ($urandom_range(4) != 0) begin
            write_csr(bavg_pkg::CSR_BLOCK_WIDTH, pick_block_size());
         end
         if ($urandom_range(4) != 0) begin
            write_csr(bavg_pkg::CSR_BLOCK_HEIGHT, pick_block_size());
         end
         frame = dim_limit(cfg_image_width, bavg_pkg::ImageSizeMax) *
                 dim_limit(cfg_image_height, bavg_pkg::ImageSizeMax);
         if (frame <= 60 && $urandom_range(3) != 0) begin
            count = frame * $urandom_range(1, 2);
         end else begin
            count = $urandom_range(1, 40);
         end
         repeat (count) pending_pixels.push_back(8'($urandom));
         sent += count;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset geometry (640x480, 8x8): a partial block, no output.
      pending_pixels.push_back(8'h00);
      pending_pixels.push_back(8'hFF);
      pending_pixels.push_back(8'h80);
      wait_drained();

      // All zeros count as 1: each pixel is its own frame. The first one
      // lands with the column count already past the new width and wraps.
      write_csr(bavg_pkg::CSR_IMAGE_WIDTH, 13'd0);
      write_csr(bavg_pkg::CSR_IMAGE_HEIGHT, 13'd0);
      write_csr(bavg_pkg::CSR_BLOCK_WIDTH, 13'd0);
      write_csr(bavg_pkg::CSR_BLOCK_HEIGHT, 13'd0);
      pending_pixels.push_back(8'hFF);
      pending_pixels.push_back(8'h00);
      pending_pixels.push_back(8'h01);
      pending_pixels.push_back(8'hFE);
      wait_drained();

      // 5x2 image, 2x2 blocks: column 4 is a leftover edge pixel. Upper
      // data bits on the block registers are junk and must be masked.
      write_csr(bavg_pkg::CSR_IMAGE_WIDTH, 13'd5);
      write_csr(bavg_pkg::CSR_IMAGE_HEIGHT, 13'd2);
      write_csr(bavg_pkg::CSR_BLOCK_WIDTH, 13'h1F82);
      write_csr(bavg_pkg::CSR_BLOCK_HEIGHT, 13'h0F02);
      pending_pixels.push_back(8'hFF);
      pending_pixels.push_back(8'hFF);
      pending_pixels.push_back(8'h00);
      pending_pixels.push_back(8'h01);
      pending_pixels.push_back(8'h4D);
      pending_pixels.push_back(8'hFF);
      pending_pixels.push_back(8'hFF);
      pending_pixels.push_back(8'h02);
      pending_pixels.push_back(8'h00);
      pending_pixels.push_back(8'hC8);
      wait_drained();

      // Oversize registers clamp to 4096 and 64.
      write_csr(bavg_pkg::CSR_IMAGE_WIDTH, 13'h1FFF);
      write_csr(bavg_pkg::CSR_IMAGE_HEIGHT, 13'h1000);
      write_csr(bavg_pkg::CSR_BLOCK_WIDTH, 13'h007F);
      write_csr(bavg_pkg::CSR_BLOCK_HEIGHT, 13'd65);
      pending_pixels.push_back(8'h00);
      pending_pixels.push_back(8'hFF);
      pending_pixels.push_back(8'h5A);
      pending_pixels.push_back(8'hA5);
      wait_drained();

      // Phase 0, no idling. A 514-wide row of 1x1 blocks overruns the
      // 512-entry column store: the last two blocks are dropped and
      // frame_end sits on column 511. The row starts mid-row, since the
      // column count carries over from the previous geometry.
      write_csr(bavg_pkg::CSR_IMAGE_WIDTH, 13'd514);
      write_csr(bavg_pkg::CSR_IMAGE_HEIGHT, 13'd1);
      write_csr(bavg_pkg::CSR_BLOCK_WIDTH, 13'd1);
      write_csr(bavg_pkg::CSR_BLOCK_HEIGHT, 13'd1);
      repeat (514) pending_pixels.push_back(8'($urandom));
      run_sessions(30);

      // Phase 1: sender idles most cycles.
      send_idle_pct = 84;
      stall_pct     = 0;
      run_sessions(30);

      // Phase 2: receiver stalls most cycles.
      send_idle_pct = 0;
      stall_pct     = 84;
      run_sessions(30);

      // Phase 3: light idling on both sides.
      send_idle_pct = 14;
      stall_pct     = 14;
      run_sessions(30);

      wait_drained();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
